// ===== hw/rtl/scsa_pkg.sv =====
// Package for the size-class slab allocator: payload types, codes, class tables.
`default_nettype none
package scsa_pkg;

  localparam int MaxPages    = 256;
  localparam int PageW       = 8;
  localparam int PtrW        = 9;
  localparam int SlotW       = 8;
  localparam int NumClasses  = 8;
  localparam int ClassW      = 3;
  localparam int HeaderBytes = 72;
  localparam logic [PtrW-1:0] Nil = '1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_READY = 3'd1,
    ST_BAD_SIZE  = 3'd2,
    ST_NO_PAGES  = 3'd3,
    ST_UNKNOWN   = 3'd4,
    ST_ALREADY   = 3'd5,
    ST_MISALIGN  = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_WALK_RD, S_WALK_CHK, S_TAKE, S_BUILD, S_GRANT_RD, S_GRANT,
    S_FREE_RD, S_FREE_CHK, S_UNLINK, S_DONE
  } state_e;

  typedef struct packed {
    logic        req_type;
    logic [15:0] req_size;
    logic [19:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [19:0] obj_addr;
    logic [11:0] slot_bytes;
    logic [2:0]  status;
  } rsp_t;

  function automatic logic [11:0] class_bytes(input logic [ClassW-1:0] c);
    class_bytes = 12'd16 << c;
  endfunction

  // floor((4096-72)/size) for each class
  function automatic logic [8:0] class_slots(input logic [ClassW-1:0] c);
    case (c)
      3'd0:    class_slots = 9'd251;
      3'd1:    class_slots = 9'd125;
      3'd2:    class_slots = 9'd62;
      3'd3:    class_slots = 9'd31;
      3'd4:    class_slots = 9'd15;
      3'd5:    class_slots = 9'd7;
      3'd6:    class_slots = 9'd3;
      default: class_slots = 9'd1;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/size_class_slab_allocator.sv =====
// Top level of the size-class slab allocator: sequencer, page tables, slot link memory.
//
//   channel  dir  handshake          payload
//   req      in   req_valid/ready    scsa_pkg::req_t
//   rsp      out  rsp_valid/ready    scsa_pkg::rsp_t
//   cfg      in   cfg_valid/ready    enable (1 bit)
//
// One request at a time. An allocate visits pages on the class list in S_WALK_RD and
// S_WALK_CHK, then grants and posts the result in S_GRANT_RD, S_GRANT and S_DONE; when
// every page is full, it ends the walk, takes a page in S_TAKE and rebuilds its slot
// list in S_BUILD, one slot at a time (up to 251 slots). A free passes S_FREE_RD,
// S_FREE_CHK, S_UNLINK and S_DONE, leaving early on a fault; a rejected request only S_DONE.
// Reset clears the class heads, counts, empty list and fresh pointer; page tables
// need no clear. The result waits in the output register while rsp_ready is low.
`default_nettype none
module size_class_slab_allocator (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire scsa_pkg::req_t req_data_i,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output scsa_pkg::rsp_t      rsp_data_o,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic           cfg_data_i
);

  // page tables and slot link memory
  logic [scsa_pkg::ClassW-1:0] pg_class_mem [scsa_pkg::MaxPages];
  logic [8:0]                  pg_cnt_mem   [scsa_pkg::MaxPages];
  logic [scsa_pkg::PtrW-1:0]   pg_head_mem  [scsa_pkg::MaxPages];
  logic [scsa_pkg::PtrW-1:0]   pg_next_mem  [scsa_pkg::MaxPages];
  logic [scsa_pkg::PtrW-1:0]   pg_prev_mem  [scsa_pkg::MaxPages];
  logic [scsa_pkg::PtrW-1:0]   link_mem     [scsa_pkg::MaxPages*256];

  logic [scsa_pkg::PtrW-1:0] class_head_q [scsa_pkg::NumClasses];
  logic [8:0]                class_cnt_q  [scsa_pkg::NumClasses];
  logic [scsa_pkg::PtrW-1:0] empty_head_q;
  logic [8:0]                fresh_q;
  logic                      enable_q;

  scsa_pkg::state_e state_q, state_d;
  scsa_pkg::req_t   req_q;
  scsa_pkg::rsp_t   rsp_q;
  logic             rsp_valid_q;

  logic [scsa_pkg::ClassW-1:0] cls_q;
  logic [scsa_pkg::PtrW-1:0]   page_q;
  logic [8:0]                  guard_q;
  logic [8:0]                  idx_q;
  logic [7:0]                  slot_q;

  // registered reads of the current page
  logic [scsa_pkg::ClassW-1:0] rd_class_q;
  logic [8:0]                  rd_cnt_q;
  logic [scsa_pkg::PtrW-1:0]   rd_head_q, rd_next_q, rd_prev_q, rd_link_q;
  logic [scsa_pkg::PtrW-1:0]   rd_empty_next_q;

  logic [7:0] pidx;
  assign pidx = page_q[7:0];

  assign req_ready  = (state_q == scsa_pkg::S_IDLE) && !rsp_valid_q;
  assign cfg_ready  = 1'b1;
  assign rsp_valid  = rsp_valid_q;
  assign rsp_data_o = rsp_q;

  // size to class
  logic [scsa_pkg::ClassW-1:0] size_cls;
  always_comb begin
    size_cls = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if (req_data_i.req_size <= (17'd16 << i)) size_cls = 3'(i);
    end
  end

  // free decode on the page's class
  logic [11:0] off;
  logic [11:0] rel;
  logic [11:0] fbytes;
  logic [8:0]  ftotal;
  logic        misal;
  logic [8:0]  fslot;
  always_comb begin
    off    = req_q.free_addr[11:0];
    rel    = off - 12'(scsa_pkg::HeaderBytes);
    fbytes = scsa_pkg::class_bytes(rd_class_q);
    ftotal = scsa_pkg::class_slots(rd_class_q);
    fslot  = 9'(rel >> ({1'b0, rd_class_q} + 4'd4));
    misal  = (off < 12'(scsa_pkg::HeaderBytes)) || ((rel & (fbytes - 12'd1)) != 12'd0)
             || (fslot >= ftotal);
  end

  logic [19:0] grant_addr;
  assign grant_addr = {pidx, 12'd0} + 20'(scsa_pkg::HeaderBytes)
                      + 20'({12'd0, slot_q} << ({1'b0, cls_q} + 4'd4));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      scsa_pkg::S_IDLE: begin
        if (req_valid && req_ready) begin
          if (!enable_q) state_d = scsa_pkg::S_DONE;
          else if (req_data_i.req_type) state_d = scsa_pkg::S_FREE_RD;
          else if (req_data_i.req_size != 16'd0 && req_data_i.req_size <= 16'd2048)
            state_d = scsa_pkg::S_WALK_RD;
          else state_d = scsa_pkg::S_DONE;
        end
      end
      scsa_pkg::S_WALK_RD:  state_d = (page_q == scsa_pkg::Nil || guard_q >= 9'd256)
                                      ? scsa_pkg::S_TAKE : scsa_pkg::S_WALK_CHK;
      scsa_pkg::S_WALK_CHK: state_d = (rd_cnt_q != 9'd0) ? scsa_pkg::S_GRANT_RD
                                                         : scsa_pkg::S_WALK_RD;
      scsa_pkg::S_TAKE: begin
        if (empty_head_q == scsa_pkg::Nil && fresh_q >= 9'd256) state_d = scsa_pkg::S_DONE;
        else state_d = scsa_pkg::S_BUILD;
      end
      scsa_pkg::S_BUILD:
        if (idx_q + 9'd1 >= scsa_pkg::class_slots(cls_q)) state_d = scsa_pkg::S_GRANT_RD;
      scsa_pkg::S_GRANT_RD: state_d = (rd_head_q == scsa_pkg::Nil) ? scsa_pkg::S_DONE
                                                                   : scsa_pkg::S_GRANT;
      scsa_pkg::S_GRANT:    state_d = scsa_pkg::S_DONE;
      scsa_pkg::S_FREE_RD:  state_d = (req_q.free_addr[19:12] >= fresh_q[7:0] && !fresh_q[8])
                                      ? scsa_pkg::S_DONE : scsa_pkg::S_FREE_CHK;
      scsa_pkg::S_FREE_CHK: state_d = (rd_cnt_q >= ftotal || misal) ? scsa_pkg::S_DONE
                                      : scsa_pkg::S_UNLINK;
      scsa_pkg::S_UNLINK:   state_d = scsa_pkg::S_DONE;
      scsa_pkg::S_DONE:     state_d = scsa_pkg::S_IDLE;
      default:              state_d = scsa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= scsa_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  // memory reads: one page's row, the empty list successor and one slot link a cycle
  always_ff @(posedge clk_i) begin
    rd_class_q      <= pg_class_mem[pidx];
    rd_cnt_q        <= pg_cnt_mem[pidx];
    rd_head_q       <= pg_head_mem[pidx];
    rd_next_q       <= pg_next_mem[pidx];
    rd_prev_q       <= pg_prev_mem[pidx];
    rd_empty_next_q <= pg_next_mem[empty_head_q[7:0]];
    rd_link_q       <= link_mem[{pidx, rd_head_q[7:0]}];
  end

  // control and table updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < scsa_pkg::NumClasses; i++) begin
        class_head_q[i] <= scsa_pkg::Nil;
        class_cnt_q[i]  <= '0;
      end
      empty_head_q <= scsa_pkg::Nil;
      fresh_q      <= '0;
      enable_q     <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) enable_q <= cfg_data_i;
      if (rsp_valid_q && rsp_ready) rsp_valid_q <= 1'b0;
      if (state_q == scsa_pkg::S_DONE) rsp_valid_q <= 1'b1;
      if (state_q == scsa_pkg::S_TAKE) begin
        if (empty_head_q != scsa_pkg::Nil) empty_head_q <= rd_empty_next_q;
        else if (fresh_q < 9'd256) fresh_q <= fresh_q + 9'd1;
        if (empty_head_q != scsa_pkg::Nil || fresh_q < 9'd256) begin
          class_head_q[cls_q] <= {1'b0, (empty_head_q != scsa_pkg::Nil) ? empty_head_q[7:0]
                                                                        : fresh_q[7:0]};
          class_cnt_q[cls_q]  <= class_cnt_q[cls_q] + 9'd1;
        end
      end
      if (state_q == scsa_pkg::S_UNLINK && rd_cnt_q + 9'd1 == ftotal
          && class_cnt_q[rd_class_q] > 9'd1) begin
        if (rd_prev_q == scsa_pkg::Nil) class_head_q[rd_class_q] <= rd_next_q;
        class_cnt_q[rd_class_q] <= class_cnt_q[rd_class_q] - 9'd1;
        empty_head_q <= page_q;
      end
    end
  end

  // datapath registers and memory writes
  always_ff @(posedge clk_i) begin
    case (state_q)
      scsa_pkg::S_IDLE: begin
        if (req_valid && req_ready) begin
          req_q   <= req_data_i;
          cls_q   <= size_cls;
          guard_q <= '0;
          page_q  <= req_data_i.req_type ? {1'b0, req_data_i.free_addr[19:12]}
                                         : class_head_q[size_cls];
          rsp_q   <= '{obj_addr: '0, slot_bytes: '0,
                       status: enable_q ? scsa_pkg::ST_BAD_SIZE : scsa_pkg::ST_NOT_READY};
        end
      end
      scsa_pkg::S_WALK_CHK: begin
        if (rd_cnt_q == 9'd0) begin
          page_q  <= rd_next_q;
          guard_q <= guard_q + 9'd1;
        end
      end
      scsa_pkg::S_TAKE: begin
        rsp_q.status <= scsa_pkg::ST_NO_PAGES;
        idx_q <= '0;
        if (empty_head_q != scsa_pkg::Nil || fresh_q < 9'd256) begin
          page_q <= {1'b0, (empty_head_q != scsa_pkg::Nil) ? empty_head_q[7:0] : fresh_q[7:0]};
          pg_class_mem[(empty_head_q != scsa_pkg::Nil) ? empty_head_q[7:0] : fresh_q[7:0]]
            <= cls_q;
          pg_cnt_mem[(empty_head_q != scsa_pkg::Nil) ? empty_head_q[7:0] : fresh_q[7:0]]
            <= scsa_pkg::class_slots(cls_q);
          pg_head_mem[(empty_head_q != scsa_pkg::Nil) ? empty_head_q[7:0] : fresh_q[7:0]]
            <= scsa_pkg::class_slots(cls_q) - 9'd1;
          pg_next_mem[(empty_head_q != scsa_pkg::Nil) ? empty_head_q[7:0] : fresh_q[7:0]]
            <= class_head_q[cls_q];
          pg_prev_mem[(empty_head_q != scsa_pkg::Nil) ? empty_head_q[7:0] : fresh_q[7:0]]
            <= scsa_pkg::Nil;
          if (class_head_q[cls_q] != scsa_pkg::Nil)
            pg_prev_mem[class_head_q[cls_q][7:0]] <=
              {1'b0, (empty_head_q != scsa_pkg::Nil) ? empty_head_q[7:0] : fresh_q[7:0]};
        end
      end
      scsa_pkg::S_BUILD: begin
        // write one slot link a cycle, highest slot comes out first
        link_mem[{pidx, idx_q[7:0]}] <= (idx_q == 9'd0) ? scsa_pkg::Nil : idx_q - 9'd1;
        idx_q <= idx_q + 9'd1;
      end
      scsa_pkg::S_GRANT_RD: begin
        rsp_q.status <= scsa_pkg::ST_NO_PAGES;
        slot_q <= rd_head_q[7:0];
      end
      scsa_pkg::S_GRANT: begin
        pg_head_mem[pidx] <= rd_link_q;
        pg_cnt_mem[pidx]  <= rd_cnt_q - 9'd1;
        rsp_q <= '{obj_addr: grant_addr, slot_bytes: scsa_pkg::class_bytes(cls_q),
                   status: scsa_pkg::ST_OK};
      end
      scsa_pkg::S_FREE_RD: rsp_q.status <= scsa_pkg::ST_UNKNOWN;
      scsa_pkg::S_FREE_CHK: begin
        slot_q <= fslot[7:0];
        if (rd_cnt_q >= ftotal) rsp_q.status <= scsa_pkg::ST_ALREADY;
        else if (misal)         rsp_q.status <= scsa_pkg::ST_MISALIGN;
        else begin
          link_mem[{pidx, fslot[7:0]}] <= rd_head_q;
          pg_head_mem[pidx] <= {1'b0, fslot[7:0]};
          pg_cnt_mem[pidx]  <= rd_cnt_q + 9'd1;
          rsp_q <= '{obj_addr: '0, slot_bytes: fbytes, status: scsa_pkg::ST_OK};
        end
      end
      scsa_pkg::S_UNLINK: begin
        if (rd_cnt_q + 9'd1 == ftotal && class_cnt_q[rd_class_q] > 9'd1) begin
          if (rd_prev_q != scsa_pkg::Nil) pg_next_mem[rd_prev_q[7:0]] <= rd_next_q;
          if (rd_next_q != scsa_pkg::Nil) pg_prev_mem[rd_next_q[7:0]] <= rd_prev_q;
          pg_next_mem[pidx] <= empty_head_q;
          pg_prev_mem[pidx] <= scsa_pkg::Nil;
        end
      end
      default: ;
    endcase
  end

  // checks
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != scsa_pkg::S_IDLE |-> !req_ready) else $error("accept while busy");
  a_done_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == scsa_pkg::S_DONE |=> rsp_valid) else $error("result lost");
  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= 9'd256) else $error("fresh pointer overflow");

endmodule
`default_nettype wire
